// File: sv/krk_pkg.sv
// Shared types and constants for the union-find spanning tree cost block.
package krk_pkg;

  // Widths of the item fields on the ports
  localparam int unsigned NODE_W      = 10;
  localparam int unsigned WEIGHT_IN_W = 32;
  localparam int unsigned TOTAL_W     = 48;

  // Function codes of an input item
  localparam logic FUNC_EDGE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_HALVE,
    ST_LINK,
    ST_DONE
  } krk_state_e;

endpackage

// File: sv/kruskal_union_find_mst.sv
// Kruskal spanning tree cost: union-find parent memory walked by a small sequencer.
//
// The user must supply edges in ascending weight order; the block itself does not enforce
// it. Each edge is handled one at a time: both end nodes are walked to their roots through
// a parent memory with one read and one write port, using path halving, and if the roots
// differ the first root is linked under the second and the weight is added to a saturating
// total. The parent memory has one registered read port, so a walk alternates a check of
// the parent just read with a halving step that points the node at its grandparent. An edge
// with a node outside the table is not walked. A clear item rewrites every parent entry,
// one per cycle. After reset the block runs the same clearing pass before it takes its
// first item. One result is produced per item, held in an output register, so the next
// item is taken while the previous result still waits.
module kruskal_union_find_mst #(
  parameter int unsigned NODES       = 1024,
  parameter int unsigned WEIGHT_BITS = 32,
  parameter int unsigned COST_BITS   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [krk_pkg::NODE_W-1:0]          node_a_i,
  input  logic [krk_pkg::NODE_W-1:0]          node_b_i,
  input  logic [krk_pkg::WEIGHT_IN_W-1:0]     weight_i,
  input  logic                                last_edge_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic [krk_pkg::TOTAL_W-1:0]         total_cost_o,
  output logic                                overflowed_o,
  output logic                                final_res_o
);
  import krk_pkg::*;

  localparam int unsigned NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned NIW    = (NW > NODE_W) ? NW : NODE_W;
  localparam int unsigned WEXT   = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
  localparam int unsigned SW     = ((COST_BITS > WEIGHT_BITS) ? COST_BITS : WEIGHT_BITS) + 1;
  localparam int unsigned CEXT   = (COST_BITS > TOTAL_W) ? COST_BITS : TOTAL_W;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  // Parent memory
  logic [NW-1:0] parent_mem [NODES];
  logic          mem_we;
  logic [NW-1:0] mem_wa, mem_wd, mem_ra, rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      parent_mem[mem_wa] <= mem_wd;
    end
    rd_q <= parent_mem[mem_ra];
  end

  krk_state_e state_q, state_d;
  logic [NW-1:0] clr_q, clr_d;
  logic          clr_pend_q, clr_pend_d;
  logic          which_q, which_d;
  logic [NW-1:0] node_q, node_d, ra_q, ra_d, nb_q, nb_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic          last_q, last_d, acc_q, acc_d;
  logic [COST_BITS-1:0] cost_q, cost_d;
  logic          sat_q, sat_d;
  logic          out_valid_q, out_valid_d, out_load;
  logic          acc_out_q, ovf_out_q, fin_out_q;
  logic [TOTAL_W-1:0] total_out_q;

  logic [NIW-1:0]  na_ext, nb_ext;
  logic [WEXT-1:0] wt_ext;
  logic [CEXT-1:0] cost_ext;
  logic [SW-1:0]   sum_ext;
  logic            a_ok, b_ok, sum_ovf;

  assign na_ext   = NIW'(node_a_i);
  assign nb_ext   = NIW'(node_b_i);
  assign wt_ext   = WEXT'(weight_i);
  assign a_ok     = 32'(node_a_i) < 32'(NODES);
  assign b_ok     = 32'(node_b_i) < 32'(NODES);
  assign sum_ext  = SW'(cost_q) + SW'(w_q);
  assign sum_ovf  = |(sum_ext >> COST_BITS);
  assign cost_ext = CEXT'(cost_q);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clr_pend_d = clr_pend_q;
    which_d    = which_q;
    node_d     = node_q;
    ra_d       = ra_q;
    nb_d       = nb_q;
    w_d        = w_q;
    last_d     = last_q;
    acc_d      = acc_q;
    cost_d     = cost_q;
    sat_d      = sat_q;
    mem_we     = 1'b0;
    mem_wa     = node_q;
    mem_wd     = rd_q;
    mem_ra     = node_q;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_NODE) begin
          clr_pend_d = 1'b0;
          state_d    = clr_pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_d = 1'b0;
          if (func_i == FUNC_CLEAR) begin
            clr_d      = '0;
            clr_pend_d = 1'b1;
            cost_d     = '0;
            sat_d      = 1'b0;
            last_d     = 1'b0;
            state_d    = ST_CLEAR;
          end else begin
            last_d = last_edge_i;
            nb_d   = nb_ext[NW-1:0];
            w_d    = wt_ext[WEIGHT_BITS-1:0];
            if (a_ok && b_ok) begin
              // Start the walk from node a straight away
              node_d  = na_ext[NW-1:0];
              mem_ra  = na_ext[NW-1:0];
              which_d = 1'b0;
              state_d = ST_CHECK;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_CHECK: begin
        if (rd_q == node_q) begin
          if (!which_q) begin
            ra_d    = node_q;
            node_d  = nb_q;
            mem_ra  = nb_q;
            which_d = 1'b1;
          end else begin
            state_d = ST_LINK;
          end
        end else begin
          // Fetch the grandparent
          mem_ra  = rd_q;
          state_d = ST_HALVE;
        end
      end
      ST_HALVE: begin
        // Point the node at its grandparent and advance to it
        mem_we  = 1'b1;
        mem_wa  = node_q;
        mem_wd  = rd_q;
        node_d  = rd_q;
        mem_ra  = rd_q;
        state_d = ST_CHECK;
      end
      ST_LINK: begin
        if (ra_q != node_q) begin
          mem_we = 1'b1;
          mem_wa = ra_q;
          mem_wd = node_q;
          acc_d  = 1'b1;
          cost_d = sum_ovf ? '1 : sum_ext[COST_BITS-1:0];
          sat_d  = sat_q | sum_ovf;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clr_pend_q  <= 1'b0;
      which_q     <= 1'b0;
      cost_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_pend_q  <= clr_pend_d;
      which_q     <= which_d;
      cost_q      <= cost_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    ra_q   <= ra_d;
    nb_q   <= nb_d;
    w_q    <= w_d;
    last_q <= last_d;
    acc_q  <= acc_d;
    if (out_load) begin
      acc_out_q   <= acc_q;
      total_out_q <= cost_ext[TOTAL_W-1:0];
      ovf_out_q   <= sat_q;
      fin_out_q   <= last_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign accepted_o   = acc_out_q;
  assign total_cost_o = total_out_q;
  assign overflowed_o = ovf_out_q;
  assign final_res_o  = fin_out_q;

  a_sat_pins_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (cost_q == {COST_BITS{1'b1}}))
    else $error("saturation flag set with total below its ceiling");

  a_halve_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HALVE) |-> (rd_q != node_q))
    else $error("path halving would point a node at itself");

  a_link_after_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> which_q)
    else $error("link reached before second root walk");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result presented outside the completion step");

endmodule
